### rtl/srf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srf_pkg
// Shared constants, register codes and the item record passed from the
// classifier front end to the run back end.
// ----------------------------------------------------------------------------
package srf_pkg;

	localparam int MAX_WIDTH_DEF  = 2048;
	localparam int MAX_HEIGHT_DEF = 4096;

	localparam int PIXEL_W     = 8;
	localparam int CFG_W       = 12;
	localparam int CFG_INDEX_W = 4;
	localparam int ROW_W       = 12;
	localparam int START_W     = 11;
	localparam int LEN_W       = 11;
	localparam int PROD_W      = 26;
	localparam int QUEUE_DEPTH = 4;

	localparam logic [PIXEL_W-1:0] SHADOW_VALUE = 8'd255;

	typedef logic [CFG_INDEX_W-1:0] cfg_index_t;

	localparam cfg_index_t REG_FRAME_WIDTH  = 4'd0;
	localparam cfg_index_t REG_FRAME_HEIGHT = 4'd1;
	localparam cfg_index_t REG_MAX_RATIO    = 4'd2;
	localparam cfg_index_t REG_MIN_RATIO    = 4'd3;

	localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 12'd640;
	localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 12'd480;
	localparam logic [CFG_W-1:0] MAX_RATIO_RST    = 12'd256;
	localparam logic [CFG_W-1:0] MIN_RATIO_RST    = 12'd0;

	typedef struct packed {
		logic               frame_start;
		logic               judged;
		logic               member;
		logic               row_end;
		logic [START_W-1:0] col;
		logic [ROW_W-1:0]   row;
		logic [PROD_W-1:0]  lim_max;
		logic [PROD_W-1:0]  lim_min;
	} srf_item_t;

endpackage

### rtl/srf_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srf_ram
// Generic simple dual-port RAM, one write port, one read port with
// registered read data (old data on a same-address collision).
// ----------------------------------------------------------------------------
module srf_ram #(
	parameter int WIDTH = 2,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### rtl/srf_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srf_front
// Accept pixels, track column and row, keep the two line stores and the
// 3x3 window, classify the centre pixel and push one item record per pixel.
// ----------------------------------------------------------------------------
module srf_front #(
	parameter int MAX_WIDTH  = srf_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = srf_pkg::MAX_HEIGHT_DEF
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      in_valid,
	output logic                                      in_ready,
	input  logic [srf_pkg::PIXEL_W-1:0]               pixel,
	input  logic                                      frame_start,
	input  logic [$clog2(MAX_WIDTH+1)-1:0]            eff_w,
	input  logic [$clog2(MAX_HEIGHT+1)-1:0]           eff_h,
	input  logic [srf_pkg::CFG_W-1:0]                 max_ratio,
	input  logic [srf_pkg::CFG_W-1:0]                 min_ratio,
	input  logic [$clog2(srf_pkg::QUEUE_DEPTH+1)-1:0] queue_count,
	output logic                                      push,
	output srf_pkg::srf_item_t                        item
);

	localparam int CW    = $clog2(MAX_WIDTH);
	localparam int WW    = $clog2(MAX_WIDTH + 1);
	localparam int RW    = $clog2(MAX_HEIGHT);
	localparam int HW    = $clog2(MAX_HEIGHT + 1);
	localparam int CNT_W = $clog2(srf_pkg::QUEUE_DEPTH + 1);
	localparam int PW    = srf_pkg::PROD_W;
	localparam int SW    = srf_pkg::START_W;
	localparam int RRW   = srf_pkg::ROW_W;
	localparam int QD    = srf_pkg::QUEUE_DEPTH;
	localparam logic [8:0] NEIGHBOR_MASK = 9'h1EF;

	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic [8:0]    window_q;

	logic          valid_s1;
	logic          cur_s1;
	logic          fs_s1;
	logic          judge_s1;
	logic          eol_s1;
	logic [CW-1:0] c_s1;
	logic [HW-1:0] i_s1;
	logic [SW-1:0] j_s1;
	logic          fwd_hit_s1;
	logic [1:0]    fwd_data_s1;

	logic          accept;
	logic          cur;
	logic [CW-1:0] c_pre;
	logic [CW-1:0] c;
	logic [RW-1:0] s_pre;
	logic [RW-1:0] s;
	logic [WW-1:0] c_inc;
	logic [HW-1:0] s_inc;
	logic [HW-1:0] i_full;
	logic          eol;
	logic          judge;
	logic [CW-1:0] j_full;
	logic [CNT_W:0] occ;

	logic [1:0]    ram_rdata;
	logic [1:0]    rd;
	logic [8:0]    window_next;
	logic          member;

	assign occ      = (CNT_W+1)'(queue_count) + (CNT_W+1)'(valid_s1);
	assign in_ready = occ < (CNT_W+1)'(QD);
	assign accept   = in_valid && in_ready;
	assign cur      = pixel == srf_pkg::SHADOW_VALUE;

	always_comb begin
		c_pre  = frame_start ? '0 : col_q;
		c      = (WW'(c_pre) >= eff_w) ? '0 : c_pre;
		s_pre  = frame_start ? '0 : row_q;
		s      = (HW'(s_pre) >= eff_h) ? '0 : s_pre;
		c_inc  = WW'(c) + WW'(1);
		s_inc  = HW'(s) + HW'(1);
		eol    = c_inc >= eff_w;
		i_full = eff_h - HW'(s);
		j_full = c - CW'(1);
		judge  = (c >= CW'(2)) && (s >= RW'(2)) && (i_full >= HW'(2));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (eol) begin
				col_q <= '0;
				row_q <= (s_inc >= eff_h) ? '0 : RW'(s_inc);
			end else begin
				col_q <= CW'(c_inc);
				row_q <= s;
			end
		end
	end

	srf_ram #(
		.WIDTH (2),
		.DEPTH (MAX_WIDTH)
	) u_line_ram (
		.clk   (clk),
		.we    (valid_s1),
		.waddr (c_s1),
		.wdata ({cur_s1, rd[1]}),
		.re    (accept),
		.raddr (c),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cur_s1      <= cur;
			fs_s1       <= frame_start;
			judge_s1    <= judge;
			eol_s1      <= eol;
			c_s1        <= c;
			i_s1        <= i_full;
			j_s1        <= SW'(j_full);
			fwd_hit_s1  <= valid_s1 && (c_s1 == c);
			fwd_data_s1 <= {cur_s1, rd[1]};
		end
	end

	always_comb begin
		rd          = fwd_hit_s1 ? fwd_data_s1 : ram_rdata;
		window_next = {cur_s1, rd[1], rd[0], window_q[8:3]};
		member      = window_next[4] && ((window_next & NEIGHBOR_MASK) != '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= '0;
		end else if (valid_s1) begin
			window_q <= window_next;
		end
	end

	assign push = valid_s1;

	always_comb begin
		item.frame_start = fs_s1;
		item.judged      = judge_s1;
		item.member      = member;
		item.row_end     = eol_s1;
		item.col         = j_s1;
		item.row         = RRW'(i_s1);
		item.lim_max     = PW'(i_s1) * PW'(max_ratio);
		item.lim_min     = PW'(i_s1) * PW'(min_ratio);
	end

endmodule

### rtl/srf_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srf_queue
// Short FIFO of item records between the classifier and the run back end.
// ----------------------------------------------------------------------------
module srf_queue (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      push,
	input  srf_pkg::srf_item_t                        din,
	input  logic                                      pop,
	output srf_pkg::srf_item_t                        dout,
	output logic                                      empty,
	output logic [$clog2(srf_pkg::QUEUE_DEPTH+1)-1:0] count
);

	localparam int DEPTH = srf_pkg::QUEUE_DEPTH;
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	srf_pkg::srf_item_t slot_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	assign dout  = slot_q[rd_ptr_q];
	assign empty = count_q == '0;
	assign count = count_q;

endmodule

### rtl/srf_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srf_back
// Pop item records, track the open run, apply the length and ratio tests
// and hold a kept run in the output register.
// ----------------------------------------------------------------------------
module srf_back #(
	parameter int MAX_WIDTH = srf_pkg::MAX_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic [$clog2(MAX_WIDTH+1)-1:0] eff_w,
	input  logic                           empty,
	input  srf_pkg::srf_item_t             item,
	output logic                           pop,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [srf_pkg::ROW_W-1:0]      run_row,
	output logic [srf_pkg::START_W-1:0]    run_start,
	output logic [srf_pkg::LEN_W-1:0]      run_length
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int PW = srf_pkg::PROD_W;
	localparam int SW = srf_pkg::START_W;
	localparam int LW = srf_pkg::LEN_W;
	localparam int TW = CW + 4;

	logic [CW-1:0]               run_q;
	logic [SW-1:0]               begin_q;
	logic                        out_valid_q;
	logic [srf_pkg::ROW_W-1:0]   row_q;
	logic [SW-1:0]               start_q;
	logic [LW-1:0]               length_q;

	logic [CW-1:0] run_base;
	logic [TW-1:0] len10;
	logic [PW-1:0] len256;
	logic          keep;

	assign pop = !empty && (!out_valid_q || out_ready);

	always_comb begin
		run_base = item.frame_start ? '0 : run_q;
		len10    = TW'({run_base, 3'b000}) + TW'({run_base, 1'b0});
		len256   = PW'({run_base, 8'h00});
		keep     = item.judged && !item.member && (run_base != '0)
		        && (len10 >= TW'(eff_w))
		        && (len256 <= item.lim_max)
		        && (len256 >= item.lim_min);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q       <= '0;
			begin_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				if (item.row_end || (item.judged && !item.member)) begin
					run_q <= '0;
				end else if (item.judged) begin
					run_q <= run_base + CW'(1);
				end else begin
					run_q <= run_base;
				end
				if (item.judged && item.member && (run_base == '0)) begin
					begin_q <= item.col;
				end
			end
			if (pop && keep) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && keep) begin
			row_q    <= item.row;
			start_q  <= begin_q;
			length_q <= LW'(run_base);
		end
	end

	assign out_valid  = out_valid_q;
	assign run_row    = row_q;
	assign run_start  = start_q;
	assign run_length = length_q;

endmodule

### rtl/shadow_run_filter_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shadow_run_filter_core
// Shadow run filter: 3x3 membership test on a binary pixel stream and
// emission of horizontal member runs that pass the length and ratio tests.
//
//   Port group   Handshake              Payload
//   in           in_valid / in_ready    pixel, frame_start
//   out          out_valid / out_ready  run_row, run_start, run_length
//   cfg          cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One pixel per cycle while in_ready is high; the line store RAM (one read
// and one write port, read data registered) and the window update set
// that figure. A kept run shows on out_valid from the output register,
// behind the classifier stage register and the item queue. in_ready drops
// when queue and stage hold QUEUE_DEPTH items, built up only while out_ready is low.
// cfg_ready is always high. Reset needs no clearing pass; line store
// contents are undefined until the first two rows of a frame have passed.
// ----------------------------------------------------------------------------
module shadow_run_filter_core #(
	parameter int MAX_WIDTH  = srf_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = srf_pkg::MAX_HEIGHT_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [srf_pkg::PIXEL_W-1:0]     pixel,
	input  logic                            frame_start,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [srf_pkg::ROW_W-1:0]       run_row,
	output logic [srf_pkg::START_W-1:0]     run_start,
	output logic [srf_pkg::LEN_W-1:0]       run_length,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [srf_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [srf_pkg::CFG_W-1:0]       cfg_data
);

	localparam int WW    = $clog2(MAX_WIDTH + 1);
	localparam int HW    = $clog2(MAX_HEIGHT + 1);
	localparam int CNT_W = $clog2(srf_pkg::QUEUE_DEPTH + 1);

	logic [srf_pkg::CFG_W-1:0] frame_width_q;
	logic [srf_pkg::CFG_W-1:0] frame_height_q;
	logic [srf_pkg::CFG_W-1:0] max_ratio_q;
	logic [srf_pkg::CFG_W-1:0] min_ratio_q;

	logic [WW-1:0]      eff_w;
	logic [HW-1:0]      eff_h;
	logic               push;
	logic               pop;
	logic               empty;
	logic [CNT_W-1:0]   queue_count;
	srf_pkg::srf_item_t front_item;
	srf_pkg::srf_item_t back_item;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= srf_pkg::FRAME_WIDTH_RST;
			frame_height_q <= srf_pkg::FRAME_HEIGHT_RST;
			max_ratio_q    <= srf_pkg::MAX_RATIO_RST;
			min_ratio_q    <= srf_pkg::MIN_RATIO_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				srf_pkg::REG_FRAME_WIDTH: begin
					frame_width_q <= cfg_data;
				end
				srf_pkg::REG_FRAME_HEIGHT: begin
					frame_height_q <= cfg_data;
				end
				srf_pkg::REG_MAX_RATIO: begin
					max_ratio_q <= cfg_data;
				end
				srf_pkg::REG_MIN_RATIO: begin
					min_ratio_q <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		if (frame_width_q == '0) begin
			eff_w = WW'(1);
		end else if (32'(frame_width_q) > MAX_WIDTH) begin
			eff_w = WW'(MAX_WIDTH);
		end else begin
			eff_w = WW'(frame_width_q);
		end
		if (frame_height_q == '0) begin
			eff_h = HW'(1);
		end else if (32'(frame_height_q) > MAX_HEIGHT) begin
			eff_h = HW'(MAX_HEIGHT);
		end else begin
			eff_h = HW'(frame_height_q);
		end
	end

	srf_front #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.pixel       (pixel),
		.frame_start (frame_start),
		.eff_w       (eff_w),
		.eff_h       (eff_h),
		.max_ratio   (max_ratio_q),
		.min_ratio   (min_ratio_q),
		.queue_count (queue_count),
		.push        (push),
		.item        (front_item)
	);

	srf_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (front_item),
		.pop    (pop),
		.dout   (back_item),
		.empty  (empty),
		.count  (queue_count)
	);

	srf_back #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.eff_w      (eff_w),
		.empty      (empty),
		.item       (back_item),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.run_row    (run_row),
		.run_start  (run_start),
		.run_length (run_length)
	);

endmodule

### rtl/srf_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srf_checker
// Port-level checks on the shadow run filter, bound to the top level.
// ----------------------------------------------------------------------------
module srf_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            in_ready,
	input logic                            out_valid,
	input logic                            out_ready,
	input logic [srf_pkg::ROW_W-1:0]       run_row,
	input logic [srf_pkg::START_W-1:0]     run_start,
	input logic [srf_pkg::LEN_W-1:0]       run_length,
	input logic                            cfg_ready
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(run_row)
			&& $stable(run_start) && $stable(run_length))
		else $error("result item changed while stalled");

	a_len_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> run_length != '0)
		else $error("result item with zero run length");

	a_no_result_without_input: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> !out_valid)
		else $error("result item shown right after reset");

	a_cfg_open: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> cfg_ready)
		else $error("configuration port blocked");

	a_accept_drains: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid || $past(out_valid))
		else $error("input held off with no result pending");

endmodule

bind shadow_run_filter_core srf_checker u_srf_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_ready   (in_ready),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.run_row    (run_row),
	.run_start  (run_start),
	.run_length (run_length),
	.cfg_ready  (cfg_ready)
);
